/* sv/nbt_pkg.sv */
// ----------------------------------------------------------------------------
// nbt_pkg
// types and constants of the blob track table
// ----------------------------------------------------------------------------
package nbt_pkg;
    localparam int MAX_TRACKS_DEF = 16;
    localparam logic [15:0] TOL_RESET = 16'd500;
    localparam logic [31:0] TIMEOUT_RESET = 32'd200000;

    localparam logic [2:0] EV_ADDED   = 3'd0;
    localparam logic [2:0] EV_UPDATED = 3'd1;
    localparam logic [2:0] EV_REMOVED = 3'd2;
    localparam logic [2:0] EV_DROPPED = 3'd3;
    localparam logic [2:0] EV_DONE    = 3'd4;

    localparam logic [0:0] REG_TOL     = 1'b0;
    localparam logic [0:0] REG_TIMEOUT = 1'b1;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [15:0]        mass;
        logic [31:0]        ident;
        logic [47:0]        first;
        logic [47:0]        last;
    } track_t;

    typedef struct packed {
        logic [2:0]         event_kind;
        logic [31:0]        track_id;
        logic signed [15:0] out_x;
        logic signed [15:0] out_y;
        logic [15:0]        out_mass;
        logic [47:0]        first_seen;
        logic [47:0]        last_seen;
        logic               last_of_run;
    } result_t;

    // control from the sequencer to every cell
    typedef struct packed {
        logic shift;     // rotate the ring by one place
        logic keep;      // head entry goes to the tail (else dropped)
        logic load;      // overwrite the entry at load_pos with the loaded track
    } cell_ctl_t;
endpackage

/* sv/nbt_if.sv */
// ----------------------------------------------------------------------------
// nbt_if
// valid / ready channels of the blob track table
// ----------------------------------------------------------------------------
interface nbt_in_if;
    logic               valid;
    logic               ready;
    logic               opcode;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [15:0]        blob_mass;
    logic [47:0]        now_us;
    modport source (output valid, opcode, pos_x, pos_y, blob_mass, now_us, input ready);
    modport sink (input valid, opcode, pos_x, pos_y, blob_mass, now_us, output ready);
endinterface

interface nbt_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         event_kind;
    logic [31:0]        track_id;
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic [15:0]        out_mass;
    logic [47:0]        first_seen;
    logic [47:0]        last_seen;
    logic               last_of_run;
    modport source (output valid, event_kind, track_id, out_x, out_y, out_mass,
                    first_seen, last_seen, last_of_run, input ready);
    modport sink (input valid, event_kind, track_id, out_x, out_y, out_mass,
                  first_seen, last_seen, last_of_run, output ready);
endinterface

interface nbt_cfg_if;
    logic        valid;
    logic        ready;
    logic [0:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

/* sv/nbt_cell.sv */
// ----------------------------------------------------------------------------
// nbt_cell
// one table slot; the first len slots form a ring that rotates one place
// per step, the last slot of the ring takes the head or holds
// ----------------------------------------------------------------------------
module nbt_cell
    import nbt_pkg::*;
#(
    parameter int IDX = 0,
    parameter int CW  = 5
)
(
    input  logic          clk,
    input  cell_ctl_t     ctl,
    input  logic [CW-1:0] len,
    input  logic [CW-1:0] load_pos,
    input  track_t        head,
    input  track_t        nxt,
    input  track_t        load_trk,
    output track_t        trk
);
    track_t trk_reg;
    logic   in_ring;
    logic   at_tail;

    assign in_ring = (CW'(IDX) < len);
    assign at_tail = (CW'(IDX + 1) == len);

    always_ff @(posedge clk)
    begin
        if (ctl.load && load_pos == CW'(IDX))
            trk_reg <= load_trk;
        else if (ctl.shift && in_ring)
        begin
            if (!at_tail)
                trk_reg <= nxt;
            else if (ctl.keep)
                trk_reg <= head;
        end
    end

    assign trk = trk_reg;
endmodule

/* sv/nbt_dist.sv */
// ----------------------------------------------------------------------------
// nbt_dist
// squared center distance of the head track, registered after the multiply
// ----------------------------------------------------------------------------
module nbt_dist
    import nbt_pkg::*;
(
    input  logic               clk,
    input  logic signed [15:0] ax,
    input  logic signed [15:0] ay,
    input  logic signed [15:0] bx,
    input  logic signed [15:0] by,
    output logic [32:0]        sqd
);
    logic signed [16:0] dx, dy;
    logic [16:0] mx, my;
    logic [33:0] sx_reg, sy_reg;
    assign dx = 17'(ax) - 17'(bx);
    assign dy = 17'(ay) - 17'(by);
    assign mx = dx[16] ? 17'(-dx) : 17'(dx);
    assign my = dy[16] ? 17'(-dy) : 17'(dy);
    always_ff @(posedge clk)
    begin
        sx_reg <= 34'(mx) * 34'(mx);
        sy_reg <= 34'(my) * 34'(my);
    end
    assign sqd = 33'(sx_reg + sy_reg);
endmodule

/* sv/nearest_blob_track_table.sv */
// ----------------------------------------------------------------------------
// nearest_blob_track_table
// detection: scan over the stored tracks, then a write state that updates, adds
//   or drops the track and registers the result; next request after it is taken
// sweep: steps through the table, stalling while a result waits
// one request at a time
// rst_n clears count, ident counter and registers, async
// ----------------------------------------------------------------------------
module nearest_blob_track_table
    import nbt_pkg::*;
#(
    parameter int MAX_TRACKS = MAX_TRACKS_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    nbt_in_if.sink    in_ch,
    nbt_out_if.source out_ch,
    nbt_cfg_if.sink   cfg
);
    localparam int CW = $clog2(MAX_TRACKS + 1);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_WRITE = 5'b00100,
        S_SWEEP = 5'b01000,
        S_DRAIN = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic [CW-1:0] count_reg, len_reg, idx_reg, best_reg, dpos_reg;
    logic [31:0] ident_reg;
    logic [15:0] tol_reg;
    logic [31:0] tmo_reg;
    track_t      det_reg;
    logic        found_reg;
    logic [32:0] best_d_reg;
    logic [31:0] best_ident_reg;
    logic [47:0] best_first_reg;
    logic [31:0] hd_ident_reg;
    logic [47:0] hd_first_reg;
    logic        dv_reg;
    result_t     res_reg, res_next;
    logic        res_valid_reg, res_valid_next;
    logic        emit;

    track_t    cells [MAX_TRACKS];
    cell_ctl_t ctl;
    logic [CW-1:0] load_pos;
    track_t    load_trk;
    logic [32:0] sqd;
    track_t    head;
    assign head = cells[0];

    // ring over the first len_reg cells: cell i takes cell i+1
    for (genvar g = 0; g < MAX_TRACKS; g++)
    begin : g_cell
        nbt_cell #(.IDX(g), .CW(CW)) u_cell (
            .clk(clk), .ctl(ctl), .len(len_reg), .load_pos(load_pos),
            .head(cells[0]), .nxt(cells[(g + 1) % MAX_TRACKS]),
            .load_trk(load_trk), .trk(cells[g])
        );
    end

    nbt_dist u_dist (
        .clk(clk), .ax(det_reg.x), .ay(det_reg.y),
        .bx(head.x), .by(head.y), .sqd(sqd)
    );

    logic [31:0] tol2;
    logic [47:0] age;
    logic        stale;
    logic        full;
    logic        out_free;
    logic        at_end;
    assign tol2 = 32'(tol_reg) * 32'(tol_reg);
    assign age = det_reg.last - head.last;
    assign stale = (age > 48'(tmo_reg));
    assign full = (count_reg == CW'(MAX_TRACKS));
    assign out_free = !res_valid_reg || out_ch.ready;
    assign at_end = (idx_reg == count_reg);

    always_comb
    begin
        ctl = '0;
        load_pos = count_reg;
        load_trk = det_reg;
        state_next = state_reg;
        emit = 1'b0;
        res_next = '0;
        res_next.last_of_run = 1'b1;
        unique case (state_reg)
            S_IDLE:
                if (in_ch.valid) state_next = in_ch.opcode ? S_SWEEP : S_SCAN;
            S_SCAN:
            begin
                ctl.shift = !at_end;
                ctl.keep = 1'b1;
                if (at_end) state_next = S_WRITE;
            end
            S_WRITE:
            begin
                emit = 1'b1;
                res_next.out_x = det_reg.x;
                res_next.out_y = det_reg.y;
                res_next.out_mass = det_reg.mass;
                res_next.last_seen = det_reg.last;
                if (found_reg)
                begin
                    ctl.load = 1'b1;
                    load_pos = best_reg;
                    load_trk.ident = best_ident_reg;
                    load_trk.first = best_first_reg;
                    res_next.event_kind = EV_UPDATED;
                    res_next.track_id = best_ident_reg;
                    res_next.first_seen = best_first_reg;
                end
                else if (!full)
                begin
                    ctl.load = 1'b1;
                    load_trk.ident = ident_reg;
                    res_next.event_kind = EV_ADDED;
                    res_next.track_id = ident_reg;
                    res_next.first_seen = det_reg.last;
                end
                else
                begin
                    res_next = '0;
                    res_next.event_kind = EV_DROPPED;
                    res_next.last_of_run = 1'b1;
                end
                state_next = S_DRAIN;
            end
            S_SWEEP:
            begin
                if (at_end)
                begin
                    if (out_free)
                    begin
                        emit = 1'b1;
                        res_next.event_kind = EV_DONE;
                        state_next = S_DRAIN;
                    end
                end
                else if (!stale)
                begin
                    ctl.shift = 1'b1;
                    ctl.keep = 1'b1;
                end
                else if (out_free)
                begin
                    // stale head leaves the ring, the ring gets one shorter
                    ctl.shift = 1'b1;
                    emit = 1'b1;
                    res_next.event_kind = EV_REMOVED;
                    res_next.track_id = head.ident;
                    res_next.out_x = head.x;
                    res_next.out_y = head.y;
                    res_next.out_mass = head.mass;
                    res_next.first_seen = head.first;
                    res_next.last_seen = head.last;
                    res_next.last_of_run = 1'b0;
                end
            end
            S_DRAIN:
                if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
        res_valid_next = emit || (res_valid_reg && !out_ch.ready);
    end

    assign in_ch.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            len_reg <= '0;
            ident_reg <= '0;
            tol_reg <= TOL_RESET;
            tmo_reg <= TIMEOUT_RESET;
            res_valid_reg <= 1'b0;
            res_reg <= '0;
            idx_reg <= '0;
            best_reg <= '0;
            dpos_reg <= '0;
            found_reg <= 1'b0;
            best_d_reg <= '0;
            best_ident_reg <= '0;
            best_first_reg <= '0;
            hd_ident_reg <= '0;
            hd_first_reg <= '0;
            dv_reg <= 1'b0;
            det_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            res_valid_reg <= res_valid_next;
            if (emit) res_reg <= res_next;
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    REG_TOL:     tol_reg <= cfg.data[15:0];
                    REG_TIMEOUT: tmo_reg <= cfg.data;
                    default: ;
                endcase
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    idx_reg <= '0;
                    len_reg <= count_reg;
                    found_reg <= 1'b0;
                    dv_reg <= 1'b0;
                    if (in_ch.valid)
                    begin
                        det_reg.x <= in_ch.pos_x;
                        det_reg.y <= in_ch.pos_y;
                        det_reg.mass <= in_ch.blob_mass;
                        det_reg.last <= in_ch.now_us;
                        det_reg.ident <= '0;
                        det_reg.first <= in_ch.now_us;
                    end
                end
                S_SCAN:
                begin
                    if (ctl.shift) idx_reg <= idx_reg + CW'(1);
                    // distance of the previous head arrives now
                    dv_reg <= ctl.shift;
                    dpos_reg <= idx_reg;
                    hd_ident_reg <= head.ident;
                    hd_first_reg <= head.first;
                    if (dv_reg && sqd <= 33'(tol2) && (!found_reg || sqd < best_d_reg))
                    begin
                        found_reg <= 1'b1;
                        best_d_reg <= sqd;
                        best_reg <= dpos_reg;
                        best_ident_reg <= hd_ident_reg;
                        best_first_reg <= hd_first_reg;
                    end
                end
                S_WRITE:
                begin
                    if (!found_reg && !full)
                    begin
                        ident_reg <= ident_reg + 32'd1;
                        count_reg <= count_reg + CW'(1);
                    end
                end
                S_SWEEP:
                begin
                    if (at_end)
                    begin
                        if (out_free) count_reg <= len_reg;
                    end
                    else if (ctl.shift)
                    begin
                        idx_reg <= idx_reg + CW'(1);
                        if (!ctl.keep) len_reg <= len_reg - CW'(1);
                    end
                end
                S_DRAIN: ;
                default: ;
            endcase
        end
    end

    assign out_ch.valid = res_valid_reg;
    assign out_ch.event_kind = res_reg.event_kind;
    assign out_ch.track_id = res_reg.track_id;
    assign out_ch.out_x = res_reg.out_x;
    assign out_ch.out_y = res_reg.out_y;
    assign out_ch.out_mass = res_reg.out_mass;
    assign out_ch.first_seen = res_reg.first_seen;
    assign out_ch.last_seen = res_reg.last_seen;
    assign out_ch.last_of_run = res_reg.last_of_run;
endmodule

/* dv/nbt_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nbt_checker
// watches the request, result and register channels of the blob track table,
// keeps its own copy of the track table, predicts every result and compares
// them in order, over all fields
// ----------------------------------------------------------------------------
module nbt_checker
    import nbt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    nbt_in_if  in_ch,
    nbt_out_if out_ch,
    nbt_cfg_if cfg,
    output int errors,
    output int pending
);
    track_t    tracks[$];
    logic [31:0] next_id;
    logic [15:0] tol;
    logic [31:0] timeout;
    result_t   expected_q[$];

    function automatic logic [33:0] sq_dist(logic signed [15:0] a, logic signed [15:0] b);
        logic signed [17:0] d;
        d = 18'(a) - 18'(b);
        return 34'(d) * 34'(d);
    endfunction

    function automatic result_t track_result(logic [2:0] kind, track_t t);
        result_t r;
        r = '0;
        r.event_kind = kind;
        r.track_id = t.ident;
        r.out_x = t.x;
        r.out_y = t.y;
        r.out_mass = t.mass;
        r.first_seen = t.first;
        r.last_seen = t.last;
        return r;
    endfunction

    task automatic predict_request();
        result_t r;
        track_t t;
        track_t kept[$];
        logic [34:0] d;
        logic [34:0] best;
        logic [31:0] tol2;
        logic [47:0] age;
        int bi;
        bi = -1;
        best = '0;
        if (in_ch.opcode == 1'b0)
        begin
            tol2 = tol * tol;
            foreach (tracks[i])
            begin
                d = sq_dist(in_ch.pos_x, tracks[i].x) + sq_dist(in_ch.pos_y, tracks[i].y);
                if (d <= tol2 && (bi < 0 || d < best))
                begin
                    bi = i;
                    best = d;
                end
            end
            if (bi >= 0)
            begin
                tracks[bi].x = in_ch.pos_x;
                tracks[bi].y = in_ch.pos_y;
                tracks[bi].mass = in_ch.blob_mass;
                tracks[bi].last = in_ch.now_us;
                r = track_result(EV_UPDATED, tracks[bi]);
            end
            else if (tracks.size() < MAX_TRACKS_DEF)
            begin
                t.x = in_ch.pos_x;
                t.y = in_ch.pos_y;
                t.mass = in_ch.blob_mass;
                t.ident = next_id;
                t.first = in_ch.now_us;
                t.last = in_ch.now_us;
                next_id = next_id + 32'd1;
                tracks = {tracks, t};
                r = track_result(EV_ADDED, t);
            end
            else
            begin
                r = '0;
                r.event_kind = EV_DROPPED;
            end
        end
        else
        begin
            foreach (tracks[i])
            begin
                age = in_ch.now_us - tracks[i].last;
                if (age > 48'(timeout))
                    expected_q = {expected_q, track_result(EV_REMOVED, tracks[i])};
                else
                    kept = {kept, tracks[i]};
            end
            tracks = kept;
            r = '0;
            r.event_kind = EV_DONE;
        end
        r.last_of_run = 1'b1;
        expected_q = {expected_q, r};
    endtask

    task automatic compare_result();
        result_t got;
        result_t want;
        got = '{out_ch.event_kind, out_ch.track_id, out_ch.out_x, out_ch.out_y,
                out_ch.out_mass, out_ch.first_seen, out_ch.last_seen, out_ch.last_of_run};
        if (expected_q.size() == 0)
        begin
            errors++;
            if (errors <= 10)
                $display("unexpected result %p", got);
            return;
        end
        want = expected_q.pop_front();
        if (got !== want)
        begin
            errors++;
            if (errors <= 10)
                $display("mismatch: expected %p, got %p", want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tracks.delete();
            expected_q.delete();
            next_id = '0;
            tol = TOL_RESET;
            timeout = TIMEOUT_RESET;
            errors = 0;
            pending = 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
                compare_result();
            if (in_ch.valid && in_ch.ready)
                predict_request();
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == REG_TOL)
                    tol = cfg.data[15:0];
                else
                    timeout = cfg.data;
            end
            pending = expected_q.size();
        end
    end
endmodule

/* dv/nearest_blob_track_table_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nearest_blob_track_table_test
// drives detections and sweeps with random gaps and result stalls through
// several register settings; the checker predicts and compares every result
// ----------------------------------------------------------------------------
module nearest_blob_track_table_test;
    import nbt_pkg::*;

    localparam longint CYCLE_LIMIT = 400000;

    logic clk;
    logic rst_n;
    int   errors;
    int   pending;
    longint cycles;
    bit   long_hold;
    logic [47:0] clock_us;

    nbt_in_if  in_ch();
    nbt_out_if out_ch();
    nbt_cfg_if cfg();

    nearest_blob_track_table dut (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg(cfg));

    nbt_checker checker_i (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg(cfg),
        .errors(errors), .pending(pending));

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // result side: random stalls, plus one long hold-off
    initial
    begin
        int gap;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (long_hold)
            begin
                out_ch.ready <= 1'b0;
                repeat (300) @(posedge clk);
                long_hold = 1'b0;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
            if (gap > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge clk);
            while (!out_ch.valid)
                @(posedge clk);
        end
    end

    task automatic send_request(logic op, logic signed [15:0] x, logic signed [15:0] y,
                                logic [15:0] mass, logic [47:0] now, bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 18);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.opcode <= op;
        in_ch.pos_x <= x;
        in_ch.pos_y <= y;
        in_ch.blob_mass <= mass;
        in_ch.now_us <= now;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [0:0] index, logic [31:0] data);
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= index;
        cfg.data <= data;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        cfg.valid <= 1'b0;
    endtask

    task automatic random_request(bit near, bit no_gap);
        logic signed [15:0] x;
        logic signed [15:0] y;
        clock_us = clock_us + $urandom_range(0, 60000);
        if (near)
        begin
            x = 16'($urandom_range(0, 6)) * 16'sd300 - 16'sd900 + 16'($urandom_range(0, 40));
            y = 16'($urandom_range(0, 3)) * 16'sd400 + 16'($urandom_range(0, 40));
        end
        else
        begin
            x = 16'($urandom);
            y = 16'($urandom);
        end
        if ($urandom_range(0, 9) == 0)
            send_request(1'b1, 16'($urandom), 16'($urandom), 16'($urandom),
                         ($urandom_range(0, 30) == 0) ? 48'({$urandom, $urandom}) : clock_us,
                         no_gap);
        else
            send_request(1'b0, x, y, 16'($urandom), clock_us, no_gap);
    endtask

    initial
    begin
        logic [47:0] tmax;
        rst_n = 1'b0;
        long_hold = 1'b0;
        clock_us = 48'd1000;
        tmax = '1;
        in_ch.valid = 1'b0;
        in_ch.opcode = 1'b0;
        in_ch.pos_x = '0;
        in_ch.pos_y = '0;
        in_ch.blob_mass = '0;
        in_ch.now_us = '0;
        cfg.valid = 1'b0;
        cfg.index = REG_TOL;
        cfg.data = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, full table, sweeps, time going backwards
        send_request(1'b0, 16'sh7fff, 16'sh7fff, 16'hffff, 48'd0, 0);
        send_request(1'b0, 16'sh8000, 16'sh8000, 16'h0000, 48'd10, 0);
        send_request(1'b0, 16'sh7fff, 16'sh7fff, 16'h1234, 48'd20, 0);
        send_request(1'b0, 16'sd0, 16'sd0, 16'd5, 48'd30, 0);
        send_request(1'b0, 16'sd200, 16'sd0, 16'd6, 48'd40, 0);
        send_request(1'b0, 16'sd100, 16'sd0, 16'd7, 48'd50, 0);
        for (int i = 0; i < 13; i++)
            send_request(1'b0, 16'(i * 2000 - 20000), 16'sd9000, 16'(i), 48'd60 + i, 1);
        send_request(1'b1, 16'sd0, 16'sd0, 16'd0, 48'd100, 0);
        send_request(1'b1, 16'sd0, 16'sd0, 16'd0, 48'd200051, 0);
        send_request(1'b1, 16'sd0, 16'sd0, 16'd0, tmax, 0);
        send_request(1'b1, 16'sd0, 16'sd0, 16'd0, 48'd5, 0);

        write_reg(REG_TOL, 32'hffff_0000);
        write_reg(REG_TIMEOUT, 32'hffff_ffff);
        send_request(1'b0, 16'sh7fff, 16'sh7fff, 16'd1, 48'd10, 0);
        send_request(1'b0, 16'sh8000, 16'sh8000, 16'd2, 48'd20, 0);
        send_request(1'b1, 16'sd0, 16'sd0, 16'd0, tmax, 0);

        write_reg(REG_TOL, 32'h0000_ffff);
        send_request(1'b0, 16'sh7fff, 16'sh7fff, 16'd3, 48'd30, 0);
        send_request(1'b0, 16'sh8000, 16'sh8000, 16'd4, 48'd40, 0);
        write_reg(REG_TIMEOUT, 32'd0);
        send_request(1'b1, 16'sd0, 16'sd0, 16'd0, 48'd40, 0);
        send_request(1'b1, 16'sd0, 16'sd0, 16'd0, 48'd41, 0);

        // random phases over several settings
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin write_reg(REG_TOL, 32'd500); write_reg(REG_TIMEOUT, 32'd200000); end
                1: begin write_reg(REG_TOL, 32'd60); write_reg(REG_TIMEOUT, 32'd90000); end
                2: begin write_reg(REG_TOL, 32'd0); write_reg(REG_TIMEOUT, 32'd1000000); end
                default: begin write_reg(REG_TOL, 32'd2000); write_reg(REG_TIMEOUT, 32'd30000); end
            endcase
            for (int n = 0; n < 52; n++)
            begin
                if (phase == 1 && n == 10)
                    long_hold = 1'b1;
                random_request($urandom_range(0, 4) != 0, phase == 1 && n >= 10 && n < 30);
            end
        end
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

/* nearest_blob_track_table.f */
sv/nbt_pkg.sv
sv/nbt_if.sv
sv/nbt_cell.sv
sv/nbt_dist.sv
sv/nearest_blob_track_table.sv
dv/nbt_checker.sv
dv/nearest_blob_track_table_test.sv
